@@ design/ptt_pkg.sv @@
package ptt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int SLOT_W      = 5;
    localparam int REM_W       = 5;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_PROGRAM   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNPROGRAM = 2'd2;
    localparam logic [OP_W-1:0] OP_PROCESS   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NULL_TASK   = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_PERIOD = 2'd2;
    localparam logic [ST_W-1:0] ST_TABLE_FULL  = 2'd3;

endpackage

@@ design/ptt_if.sv @@
interface ptt_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [ptt_pkg::OP_W-1:0]          operation;
    logic [ptt_pkg::ID_W-1:0]          task_id;
    logic [ptt_pkg::TIME_W-1:0]        start_offset;
    logic [ptt_pkg::TIME_W-1:0]        repeat_period;
    logic [ptt_pkg::TIME_W-1:0]        repeat_count;
    logic [ptt_pkg::SLOT_W-1:0]        free_slots;

    modport source (output valid, operation, task_id, start_offset, repeat_period,
                    repeat_count, free_slots, input ready);
    modport sink   (input valid, operation, task_id, start_offset, repeat_period,
                    repeat_count, free_slots, output ready);
endinterface

interface ptt_res_if;
    logic                              valid;
    logic                              ready;
    logic                              dispatch_valid;
    logic [ptt_pkg::ID_W-1:0]          dispatched_id;
    logic [ptt_pkg::ST_W-1:0]          status;
    logic [ptt_pkg::REM_W-1:0]         removed_count;
    logic                              last;

    modport source (output valid, dispatch_valid, dispatched_id, status, removed_count,
                    last, input ready);
    modport sink   (input valid, dispatch_valid, dispatched_id, status, removed_count,
                    last, output ready);
endinterface

@@ design/periodic_task_timer_table_core.sv @@
// channel   dir  words
// i_cmd     in   operation, task id, offset, period, count, free slots
// o_res     out  dispatch flag, id, status, removed count, last
//
// Tick and program are done in idle and load their word directly. Unprogram
// and process walk the table one entry per cycle, unless o_res stalls, through
// a single entry read port; each removal shifts the tail down one entry per
// cycle; a min-due scan follows any removal or dispatch. Process: up to three
// walks (dispatch, mark, dispatch) plus shifts and scans, then the done word.
// Reset clears counters and the entry count; entry storage is not cleared.
// A stalled o_res holds the sequencer at its next word; i_cmd waits until done.
module periodic_task_timer_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptt_cmd_if.sink    i_cmd,
    ptt_res_if.source  o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UNP   = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_MIN   = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int D  = ptt_pkg::TABLE_DEPTH;
    localparam int IW = ptt_pkg::IDX_W;
    localparam int CW = ptt_pkg::CNT_W;
    localparam int TW = ptt_pkg::TIME_W;

    logic [ptt_pkg::ID_W-1:0] r_id  [D];
    logic [TW-1:0]            r_due [D];
    logic [TW-1:0]            r_per [D];
    logic [TW-1:0]            r_rem [D];
    logic                     r_rdy [D];

    logic [2:0]                  r_state;
    logic [TW-1:0]               r_now;
    logic [TW-1:0]               r_chk;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_i;
    logic [IW-1:0]               r_j;
    logic                        r_proc;
    logic                        r_pass;
    logic                        r_any;
    logic                        r_ret_disp;
    logic [ptt_pkg::SLOT_W-1:0]  r_slots;
    logic [ptt_pkg::REM_W-1:0]   r_removed;
    logic [TW-1:0]               r_best;
    logic [ptt_pkg::ID_W-1:0]    r_tid;

    logic                        r_ov;
    logic                        r_o_dv;
    logic [ptt_pkg::ID_W-1:0]    r_o_id;
    logic [ptt_pkg::ST_W-1:0]    r_o_st;
    logic [ptt_pkg::REM_W-1:0]   r_o_rm;
    logic                        r_o_last;

    logic          w_can_emit;
    logic          w_emit;
    logic [IW-1:0] w_ridx;
    logic [IW-1:0] w_jn;
    logic          w_in_range;
    logic [TW-1:0] w_new_chk;
    logic [TW-1:0] w_sum;
    logic [TW-1:0] w_add_a;
    logic [TW-1:0] w_add_b;
    logic [ptt_pkg::ST_W-1:0] w_pst;

    assign w_can_emit = !r_ov || o_res.ready;
    assign w_jn       = r_j + 1'b1;
    assign w_ridx     = (r_state == S_SHIFT) ? w_jn : r_i[IW-1:0];
    assign w_in_range = r_i < r_cnt;

    // a word is loaded into the output register this cycle
    assign w_emit = (r_state == S_IDLE && i_cmd.valid && i_cmd.ready &&
                     (i_cmd.operation == ptt_pkg::OP_TICK ||
                      i_cmd.operation == ptt_pkg::OP_PROGRAM)) ||
                    (r_state == S_DISP && w_in_range && r_rdy[w_ridx] &&
                     r_slots != '0 && w_can_emit) ||
                    (r_state == S_DONE && w_can_emit);

    // shared adder: now+offset on program, now+period on dispatch
    assign w_add_a = r_now;
    assign w_add_b = (r_state == S_IDLE) ? i_cmd.start_offset : r_per[w_ridx];
    assign w_sum   = w_add_a + w_add_b;

    always_comb begin
        if (r_cnt == '0) begin
            w_new_chk = '0;
        end else begin
            w_new_chk = r_best;
        end
        if (i_cmd.task_id == '0) begin
            w_pst = ptt_pkg::ST_NULL_TASK;
        end else if (i_cmd.repeat_period == '0) begin
            w_pst = ptt_pkg::ST_ZERO_PERIOD;
        end else if (r_cnt >= CW'(D)) begin
            w_pst = ptt_pkg::ST_TABLE_FULL;
        end else begin
            w_pst = ptt_pkg::ST_OK;
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE) && w_can_emit;
    assign o_res.valid          = r_ov;
    assign o_res.dispatch_valid = r_o_dv;
    assign o_res.dispatched_id  = r_o_id;
    assign o_res.status         = r_o_st;
    assign o_res.removed_count  = r_o_rm;
    assign o_res.last           = r_o_last;

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid && i_cmd.ready &&
            i_cmd.operation == ptt_pkg::OP_PROGRAM && w_pst == ptt_pkg::ST_OK) begin
            r_id[r_cnt[IW-1:0]]  <= i_cmd.task_id;
            r_due[r_cnt[IW-1:0]] <= w_sum;
            r_per[r_cnt[IW-1:0]] <= i_cmd.repeat_period;
            r_rem[r_cnt[IW-1:0]] <= i_cmd.repeat_count;
            r_rdy[r_cnt[IW-1:0]] <= 1'b0;
        end
        if (r_state == S_DISP && w_in_range && r_rdy[w_ridx] && r_slots != '0 &&
            w_can_emit) begin
            r_due[w_ridx] <= w_sum;
            r_rdy[w_ridx] <= 1'b0;
            if (r_rem[w_ridx] != '0) begin
                r_rem[w_ridx] <= r_rem[w_ridx] - 1'b1;
            end
        end
        if (r_state == S_MARK && w_in_range && !r_rdy[w_ridx] &&
            r_now > r_due[w_ridx]) begin
            r_rdy[w_ridx] <= 1'b1;
        end
        if (r_state == S_SHIFT && CW'(w_jn) < r_cnt && r_j != IW'(D - 1)) begin
            r_id[r_j]  <= r_id[w_jn];
            r_due[r_j] <= r_due[w_jn];
            r_per[r_j] <= r_per[w_jn];
            r_rem[r_j] <= r_rem[w_jn];
            r_rdy[r_j] <= r_rdy[w_jn];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_chk   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_tid     <= i_cmd.task_id;
                        r_i       <= '0;
                        r_removed <= '0;
                        r_any     <= 1'b0;
                        r_pass    <= 1'b0;
                        r_slots   <= (i_cmd.free_slots > ptt_pkg::SLOT_W'(D)) ?
                                     ptt_pkg::SLOT_W'(D) : i_cmd.free_slots;
                        case (i_cmd.operation)
                            ptt_pkg::OP_TICK: begin
                                r_now    <= r_now + 1'b1;
                                r_o_dv   <= 1'b0;
                                r_o_id   <= '0;
                                r_o_st   <= ptt_pkg::ST_OK;
                                r_o_rm   <= '0;
                                r_o_last <= 1'b1;
                            end
                            ptt_pkg::OP_PROGRAM: begin
                                if (w_pst == ptt_pkg::ST_OK) begin
                                    r_cnt <= r_cnt + 1'b1;
                                    if (w_sum < r_chk) begin
                                        r_chk <= w_sum;
                                    end
                                end
                                r_o_dv   <= 1'b0;
                                r_o_id   <= '0;
                                r_o_st   <= w_pst;
                                r_o_rm   <= '0;
                                r_o_last <= 1'b1;
                            end
                            ptt_pkg::OP_UNPROGRAM: begin
                                r_proc  <= 1'b0;
                                r_state <= S_UNP;
                            end
                            default: begin
                                r_proc  <= 1'b1;
                                r_state <= S_DISP;
                            end
                        endcase
                    end
                end
                S_UNP: begin
                    if (w_in_range) begin
                        if (r_id[w_ridx] == r_tid) begin
                            r_removed  <= r_removed + 1'b1;
                            r_j        <= w_ridx;
                            r_ret_disp <= 1'b0;
                            r_state    <= S_SHIFT;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else if (r_removed != '0) begin
                        r_i     <= '0;
                        r_state <= S_MIN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DISP: begin
                    if (w_in_range) begin
                        if (r_rdy[w_ridx] && r_slots != '0) begin
                            if (w_can_emit) begin
                                r_o_dv   <= 1'b1;
                                r_o_id   <= r_id[w_ridx];
                                r_o_st   <= ptt_pkg::ST_OK;
                                r_o_rm   <= '0;
                                r_o_last <= 1'b0;
                                r_slots  <= r_slots - 1'b1;
                                r_any    <= 1'b1;
                                if (r_rem[w_ridx] == TW'(1)) begin
                                    r_j        <= w_ridx;
                                    r_ret_disp <= 1'b1;
                                    r_state    <= S_SHIFT;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else if (r_any) begin
                        r_i     <= '0;
                        r_state <= S_MIN;
                    end else if (!r_pass && r_now >= r_chk) begin
                        r_i     <= '0;
                        r_state <= S_MARK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MARK: begin
                    if (w_in_range) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i     <= '0;
                        r_pass  <= 1'b1;
                        r_any   <= 1'b0;
                        r_state <= S_DISP;
                    end
                end
                S_MIN: begin
                    if (w_in_range) begin
                        if (r_i == '0 || r_due[w_ridx] < r_best) begin
                            r_best <= r_due[w_ridx];
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_chk <= w_new_chk;
                        r_i   <= '0;
                        if (r_proc && !r_pass && r_now >= w_new_chk) begin
                            r_state <= S_MARK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    if (CW'(w_jn) < r_cnt && r_j != IW'(D - 1)) begin
                        r_j <= w_jn;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= r_ret_disp ? S_DISP : S_UNP;
                    end
                end
                S_DONE: begin
                    if (w_can_emit) begin
                        r_o_dv   <= 1'b0;
                        r_o_id   <= '0;
                        r_o_st   <= ptt_pkg::ST_OK;
                        r_o_rm   <= r_removed;
                        r_o_last <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ verif/periodic_task_timer_table_core_tb.sv @@
module periodic_task_timer_table_core_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [ptt_pkg::OP_W-1:0]   op;
        logic [ptt_pkg::ID_W-1:0]   id;
        logic [ptt_pkg::TIME_W-1:0] offset;
        logic [ptt_pkg::TIME_W-1:0] period;
        logic [ptt_pkg::TIME_W-1:0] count;
        logic [ptt_pkg::SLOT_W-1:0] slots;
        bit                         drain;   // hold this word until the table is quiet
    } t_timer_cmd;

    typedef struct {
        logic                       dispatch;
        logic [ptt_pkg::ID_W-1:0]   id;
        logic [ptt_pkg::ST_W-1:0]   status;
        logic [ptt_pkg::REM_W-1:0]  removed;
        logic                       last;
    } t_timer_res;

    logic i_clk;
    logic i_rst_n;

    ptt_cmd_if cmd();
    ptt_res_if res();

    periodic_task_timer_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    t_timer_cmd pending_cmds[$];
    t_timer_res expected_res[$];
    int         errors;
    int         cycles;
    int         cmds_accepted;

    // predicted table
    logic [ptt_pkg::ID_W-1:0]   tbl_id[ptt_pkg::TABLE_DEPTH];
    logic [ptt_pkg::TIME_W-1:0] tbl_due[ptt_pkg::TABLE_DEPTH];
    logic [ptt_pkg::TIME_W-1:0] tbl_period[ptt_pkg::TABLE_DEPTH];
    logic [ptt_pkg::TIME_W-1:0] tbl_left[ptt_pkg::TABLE_DEPTH];
    bit                         tbl_ready[ptt_pkg::TABLE_DEPTH];
    int                         tbl_count;
    logic [ptt_pkg::TIME_W-1:0] seconds_now;
    logic [ptt_pkg::TIME_W-1:0] next_check;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    initial begin
        cmd.valid = 1'b0;
        cmd.operation = ptt_pkg::OP_TICK;
        cmd.task_id = '0;
        cmd.start_offset = '0;
        cmd.repeat_period = '0;
        cmd.repeat_count = '0;
        cmd.free_slots = '0;
        res.ready = 1'b0;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    task automatic push_res(logic dv, logic [ptt_pkg::ID_W-1:0] id,
                            logic [ptt_pkg::ST_W-1:0] st,
                            logic [ptt_pkg::REM_W-1:0] rem, logic last);
        t_timer_res r;
        r.dispatch = dv;
        r.id = id;
        r.status = st;
        r.removed = rem;
        r.last = last;
        expected_res.push_back(r);
    endtask

    task automatic drop_entry(int i);
        for (int j = i; j + 1 < tbl_count; j++) begin
            tbl_id[j] = tbl_id[j+1];
            tbl_due[j] = tbl_due[j+1];
            tbl_period[j] = tbl_period[j+1];
            tbl_left[j] = tbl_left[j+1];
            tbl_ready[j] = tbl_ready[j+1];
        end
        tbl_count--;
    endtask

    task automatic rescan_check();
        logic [ptt_pkg::TIME_W-1:0] best;
        best = '0;
        for (int i = 0; i < tbl_count; i++)
            if (i == 0 || tbl_due[i] < best) best = tbl_due[i];
        next_check = best;
    endtask

    task automatic dispatch_walk(ref int slots);
        int i;
        bit any;
        i = 0;
        any = 0;
        while (i < tbl_count) begin
            if (tbl_ready[i] && slots > 0) begin
                push_res(1'b1, tbl_id[i], ptt_pkg::ST_OK, '0, 1'b0);
                slots--;
                any = 1;
                tbl_due[i] = seconds_now + tbl_period[i];
                tbl_ready[i] = 0;
                if (tbl_left[i] != 0) begin
                    tbl_left[i] = tbl_left[i] - 1;
                    if (tbl_left[i] == 0) begin
                        drop_entry(i);
                        continue;
                    end
                end
            end
            i++;
        end
        if (any) rescan_check();
    endtask

    task automatic predict_timer(t_timer_cmd c);
        logic [ptt_pkg::ST_W-1:0]   st;
        logic [ptt_pkg::TIME_W-1:0] due;
        int                         removed;
        int                         slots;
        int                         i;
        case (c.op)
            ptt_pkg::OP_TICK: begin
                seconds_now = seconds_now + 1;
                push_res(1'b0, '0, ptt_pkg::ST_OK, '0, 1'b1);
            end
            ptt_pkg::OP_PROGRAM: begin
                if (c.id == 0) st = ptt_pkg::ST_NULL_TASK;
                else if (c.period == 0) st = ptt_pkg::ST_ZERO_PERIOD;
                else if (tbl_count >= ptt_pkg::TABLE_DEPTH) st = ptt_pkg::ST_TABLE_FULL;
                else begin
                    st = ptt_pkg::ST_OK;
                    due = seconds_now + c.offset;
                    tbl_id[tbl_count] = c.id;
                    tbl_due[tbl_count] = due;
                    tbl_period[tbl_count] = c.period;
                    tbl_left[tbl_count] = c.count;
                    tbl_ready[tbl_count] = 0;
                    tbl_count++;
                    if (due < next_check) next_check = due;
                end
                push_res(1'b0, '0, st, '0, 1'b1);
            end
            ptt_pkg::OP_UNPROGRAM: begin
                i = 0;
                removed = 0;
                while (i < tbl_count) begin
                    if (tbl_id[i] == c.id) begin
                        drop_entry(i);
                        removed++;
                    end else begin
                        i++;
                    end
                end
                if (removed != 0) rescan_check();
                push_res(1'b0, '0, ptt_pkg::ST_OK, ptt_pkg::REM_W'(removed), 1'b1);
            end
            default: begin
                slots = (c.slots > ptt_pkg::TABLE_DEPTH) ? ptt_pkg::TABLE_DEPTH :
                        int'(c.slots);
                dispatch_walk(slots);
                if (seconds_now >= next_check) begin
                    for (i = 0; i < tbl_count; i++)
                        if (!tbl_ready[i] && seconds_now > tbl_due[i]) tbl_ready[i] = 1;
                    dispatch_walk(slots);
                end
                push_res(1'b0, '0, ptt_pkg::ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    function automatic t_timer_cmd make_cmd(logic [ptt_pkg::OP_W-1:0] op,
                                            logic [ptt_pkg::ID_W-1:0] id,
                                            logic [31:0] off, logic [31:0] per,
                                            logic [31:0] cnt,
                                            logic [ptt_pkg::SLOT_W-1:0] slots);
        t_timer_cmd c;
        c.op = op;
        c.id = id;
        c.offset = off;
        c.period = per;
        c.count = cnt;
        c.slots = slots;
        c.drain = 0;
        return c;
    endfunction

    function automatic t_timer_cmd random_cmd();
        t_timer_cmd c;
        int pick;
        c = make_cmd(ptt_pkg::OP_TICK, ptt_pkg::ID_W'($urandom), $urandom, $urandom,
                     $urandom, ptt_pkg::SLOT_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            c.op = ptt_pkg::OP_TICK;
        end else if (pick < 62) begin
            c.op = ptt_pkg::OP_PROGRAM;
            if ($urandom_range(0, 4) != 0) c.id = ptt_pkg::ID_W'($urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0) c.offset = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0: c.period = '0;
                1: c.period = 32'hFFFF_FFFF - $urandom_range(0, 3);
                2: ;
                default: c.period = $urandom_range(1, 4);
            endcase
            if ($urandom_range(0, 5) != 0) c.count = $urandom_range(0, 4);
        end else if (pick < 72) begin
            c.op = ptt_pkg::OP_UNPROGRAM;
            if ($urandom_range(0, 3) != 0) c.id = ptt_pkg::ID_W'($urandom_range(0, 8));
        end else begin
            c.op = ptt_pkg::OP_PROCESS;
        end
        return c;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        bit busy;
        busy = cmd.valid && !cmd.ready;
        if (!i_rst_n) begin
            cmd.valid <= 1'b0;
        end else if (!busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                cmd.valid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                cmd.valid <= 1'b0;
            end else if (pending_cmds[0].drain && (cmd.valid || expected_res.size() != 0)) begin
                cmd.valid <= 1'b0;
            end else begin
                cmd.valid <= 1'b1;
                cmd.operation <= pending_cmds[0].op;
                cmd.task_id <= pending_cmds[0].id;
                cmd.start_offset <= pending_cmds[0].offset;
                cmd.repeat_period <= pending_cmds[0].period;
                cmd.repeat_count <= pending_cmds[0].count;
                cmd.free_slots <= pending_cmds[0].slots;
                void'(pending_cmds.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: pattern stalls, one long hold-off
    int hold_left = 0;
    bit hold_done = 0;
    logic [7:0] stall_phase = '0;
    always @(posedge i_clk) begin
        stall_phase <= 8'(stall_phase + 1);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else if (!hold_done && cmds_accepted == 60) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= stall_phase[6] || ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: predict on command accept, check on result accept
    always @(posedge i_clk) begin
        t_timer_cmd c;
        t_timer_res w;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("periodic_task_timer_table_core_tb failed");
                $finish;
            end else begin
                if (cmd.valid && cmd.ready) begin
                    c = make_cmd(cmd.operation, cmd.task_id, cmd.start_offset,
                                 cmd.repeat_period, cmd.repeat_count, cmd.free_slots);
                    predict_timer(c);
                    cmds_accepted <= cmds_accepted + 1;
                end
                if (res.valid && res.ready) begin
                    if (expected_res.size() == 0) begin
                        report("unexpected word, id", 32'(res.dispatched_id), 32'd0);
                    end else begin
                        w = expected_res.pop_front();
                        if (res.dispatch_valid !== w.dispatch)
                            report("dispatch_valid", 32'(res.dispatch_valid), 32'(w.dispatch));
                        if (res.dispatched_id !== w.id)
                            report("dispatched_id", 32'(res.dispatched_id), 32'(w.id));
                        if (res.status !== w.status)
                            report("status", 32'(res.status), 32'(w.status));
                        if (res.removed_count !== w.removed)
                            report("removed_count", 32'(res.removed_count), 32'(w.removed));
                        if (res.last !== w.last) report("last", 32'(res.last), 32'(w.last));
                    end
                end
            end
        end
    end

    initial begin
        t_timer_cmd c;
        errors = 0;
        cycles = 0;
        cmds_accepted = 0;
        tbl_count = 0;
        seconds_now = '0;
        next_check = '0;

        // directed: rejections, wrap double dispatch, slot saturation, full table
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'h00, 32'd1, 32'd1, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'h05, 32'd1, 32'd0, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'h80, 32'd0, 32'd1, 32'd3, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'hFF, 32'd0, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'h01, 32'hFFFF_FFFF, 32'd2,
                                        32'd1, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 5'd31));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROCESS, 8'h00, 32'd0, 32'd0, 32'd0, 5'd31));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROCESS, 8'h00, 32'd0, 32'd0, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROCESS, 8'h00, 32'd0, 32'd0, 32'd0, 5'd1));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_UNPROGRAM, 8'h00, 32'd0, 32'd0, 32'd0,
                                        5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_UNPROGRAM, 8'hFF, 32'd0, 32'd0, 32'd0,
                                        5'd0));
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROGRAM, 8'(2 + i % 3), 32'd0, 32'd1,
                                            32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_PROCESS, 8'h00, 32'd0, 32'd0, 32'd0,
                                        5'd16));
        pending_cmds.push_back(make_cmd(ptt_pkg::OP_UNPROGRAM, 8'h03, 32'd0, 32'd0, 32'd0,
                                        5'd0));

        for (int n = 0; n < 250; n++) begin
            c = random_cmd();
            if (n == 0 || n == 150) c.drain = 1;
            pending_cmds.push_back(c);
        end

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd.valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (errors == 0) begin
            $display("periodic_task_timer_table_core_tb passed");
        end else begin
            $display("periodic_task_timer_table_core_tb failed");
        end
        $finish;
    end

endmodule
